// ===== hdl/utt_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
package utt_pkg;

   localparam int          UNIT_SLOTS          = 4;
   localparam int          QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [11:0] CAPACITY_RESET      = 12'd63;

   localparam logic [15:0] REPL_UNIT      = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SUPP_BASE      = 21'h010000;
   localparam logic [20:0] CODE_MAX       = 21'h10FFFF;
   localparam logic [20:0] TWO_BYTE_MIN   = 21'h000080;
   localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;
   localparam logic [9:0]  TEN_BIT_MASK   = 10'h3FF;

   typedef struct packed {
      logic [UNIT_SLOTS-1:0][15:0] units;
      logic [2:0]                  n_units;
      logic                        term;
      logic [11:0]                 base;
   } entry_type;

endpackage

// ===== hdl/utf8_to_utf16_transcoder_core.sv =====
// top level of the utf-8 to utf-16 transcoder
//
// req channel: one utf-8 byte per item, req_final_byte set on the last byte
// of a string. rsp channel: utf-16 code units, each with the running unit
// count; rsp_run_last marks the last result caused by an input item, and
// rsp_string_end marks the zero terminator sent after every final byte.
// csr_write_enable loads the unit capacity register read by the decoder.
// a byte is decoded in the cycle it is accepted and its burst (zero to five
// results) is queued, then walked out through the result register.
// bytes are taken one per cycle while the queue is not full and results leave
// one per cycle while rsp_ready is high; a burst is sent one result at a time,
// and the queue depth sets how many bursts may wait before req_ready drops.
// a stalled receiver holds the result register and fills the queue, after
// which req_ready goes low. reset clears the decoder state, the queue and
// the valid bit of the result register, and sets the capacity to 63 units.
module utf8_to_utf16_transcoder_core #(
   parameter int QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_run_last,
   output logic        rsp_string_end,
   output logic [11:0] rsp_unit_count,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);
   import utt_pkg::*;

   logic [11:0] capacity_ff, capacity_in;
   logic        accept, push, pop, q_full, q_empty;
   entry_type   push_entry, head;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   utt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .final_byte    (req_final_byte),
      .unit_capacity (capacity_ff),
      .push          (push),
      .entry         (push_entry)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   utt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (q_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end),
      .rsp_unit_count (rsp_unit_count)
   );

endmodule

// ===== hdl/utt_front.sv =====
// front end: decodes one byte per item, applies capacity and queues the burst
module utt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               final_byte,
   input  logic [11:0]        unit_capacity,
   output logic               push,
   output utt_pkg::entry_type entry
);
   import utt_pkg::*;

   logic [20:0] code_bits_ff, code_bits_in;
   logic [1:0]  expected_ff, expected_in;
   logic [1:0]  seen_ff, seen_in;
   logic [11:0] written_ff, written_in;
   logic        full_ff, full_in;

   logic        pend, cont;
   logic [2:0]  k1, k2, m, t, kept, avail;
   logic [15:0] m0, m1;
   logic [20:0] gathered, vbits;
   logic [1:0]  seen_next;
   logic        bad;
   logic [11:0] diff;
   logic        full_next;
   logic [15:0] slot_unit [UNIT_SLOTS];

   always_comb begin
      pend         = expected_ff != 2'd0;
      cont         = data_byte[7:6] == 2'b10;
      k1           = 3'd0;
      k2           = 3'd0;
      m            = 3'd0;
      m0           = REPL_UNIT;
      m1           = REPL_UNIT;
      code_bits_in = code_bits_ff;
      expected_in  = expected_ff;
      seen_in      = seen_ff;
      gathered     = {code_bits_ff[14:0], data_byte[5:0]};
      seen_next    = seen_ff + 2'd1;
      vbits        = gathered - SUPP_BASE;
      bad          = 1'b0;
      if (!full_ff) begin
         if (!pend || !cont) begin
            if (pend) begin
               k1 = {1'b0, seen_ff} + 3'd1;
            end
            code_bits_in = '0;
            expected_in  = 2'd0;
            seen_in      = 2'd0;
            if (!data_byte[7]) begin
               m  = 3'd1;
               m0 = {8'd0, data_byte};
            end else if (data_byte[7:5] == 3'b110) begin
               expected_in  = 2'd1;
               code_bits_in = {16'd0, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
               expected_in  = 2'd2;
               code_bits_in = {17'd0, data_byte[3:0]};
            end else if (data_byte[7:3] == 5'b11110) begin
               expected_in  = 2'd3;
               code_bits_in = {18'd0, data_byte[2:0]};
            end else begin
               m = 3'd1;
            end
         end else begin
            code_bits_in = gathered;
            seen_in      = seen_next;
            if (seen_next == expected_ff) begin
               case (expected_ff)
                  2'd1: begin
                     bad = gathered < TWO_BYTE_MIN;
                  end
                  2'd2: begin
                     bad = gathered < THREE_BYTE_MIN || gathered[15:11] == 5'b11011;
                  end
                  default: begin
                     bad = gathered < SUPP_BASE || gathered > CODE_MAX;
                  end
               endcase
               code_bits_in = '0;
               expected_in  = 2'd0;
               seen_in      = 2'd0;
               if (bad) begin
                  m = 3'd1;
               end else if (expected_ff == 2'd3) begin
                  m  = 3'd2;
                  m0 = HIGH_SURR_BASE + {6'd0, vbits[19:10] & TEN_BIT_MASK};
                  m1 = LOW_SURR_BASE + {6'd0, vbits[9:0]};
               end else begin
                  m  = 3'd1;
                  m0 = gathered[15:0];
               end
            end
         end
      end
      if (final_byte && expected_in != 2'd0) begin
         k2 = {1'b0, seen_in} + 3'd1;
      end
      t = k1 + m + k2;
      for (int i = 0; i < UNIT_SLOTS; i++) begin
         if (3'(i) < k1) begin
            slot_unit[i] = REPL_UNIT;
         end else if (3'(i) < k1 + m) begin
            slot_unit[i] = (3'(i) == k1) ? m0 : m1;
         end else begin
            slot_unit[i] = REPL_UNIT;
         end
      end
      diff = unit_capacity - written_ff;
      if (unit_capacity <= written_ff) begin
         avail = 3'd0;
      end else if (diff > 12'd7) begin
         avail = 3'd7;
      end else begin
         avail = diff[2:0];
      end
      if (m == 3'd2) begin
         kept = (avail >= 3'd2) ? 3'd2 : 3'd0;
      end else begin
         kept = (t < avail) ? t : avail;
      end
      full_next = full_ff || (kept < t);
      if (final_byte || full_next) begin
         code_bits_in = '0;
         expected_in  = 2'd0;
         seen_in      = 2'd0;
      end
      written_in = final_byte ? 12'd0 : written_ff + {9'd0, kept};
      full_in    = final_byte ? 1'b0 : full_next;
      for (int i = 0; i < UNIT_SLOTS; i++) begin
         entry.units[i] = slot_unit[i];
      end
      entry.n_units = kept;
      entry.term    = final_byte;
      entry.base    = written_ff;
      push          = accept && (kept != 3'd0 || final_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff <= '0;
         expected_ff  <= '0;
         seen_ff      <= '0;
         written_ff   <= '0;
         full_ff      <= 1'b0;
      end else if (accept) begin
         code_bits_ff <= code_bits_in;
         expected_ff  <= expected_in;
         seen_ff      <= seen_in;
         written_ff   <= written_in;
         full_ff      <= full_in;
      end
   end

endmodule

// ===== hdl/utt_queue.sv =====
// short queue of decoded bursts between front and back
module utt_queue #(
   parameter int DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  utt_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output utt_pkg::entry_type head
);
   import utt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == CNT_W'(DEPTH);
      empty     = count_ff == '0;
      head      = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) full |-> !push || pop)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
`endif

endmodule

// ===== hdl/utt_back.sv =====
// back end: walks each queued burst and drives the result register
module utt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  utt_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_code_unit,
   output logic               rsp_run_last,
   output logic               rsp_string_end,
   output logic [11:0]        rsp_unit_count
);
   import utt_pkg::*;

   logic        valid_ff, valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] unit_ff, unit_in;
   logic        last_ff, last_in;
   logic        end_ff, end_in;
   logic [11:0] count_ff, count_in;

   logic       load;
   logic [2:0] n_res;

   always_comb begin
      n_res    = head.n_units + {2'd0, head.term};
      load     = !empty && (!valid_ff || rsp_ready);
      last_in  = idx_ff == n_res - 3'd1;
      pop      = load && last_in;
      valid_in = load || (valid_ff && !rsp_ready);
      idx_in   = idx_ff;
      if (load) begin
         idx_in = last_in ? 3'd0 : idx_ff + 3'd1;
      end
      if (idx_ff < head.n_units) begin
         unit_in  = head.units[idx_ff[1:0]];
         end_in   = 1'b0;
         count_in = head.base + {9'd0, idx_ff} + 12'd1;
      end else begin
         unit_in  = 16'd0;
         end_in   = 1'b1;
         count_in = head.base + {9'd0, head.n_units};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff  <= unit_in;
         last_ff  <= last_in;
         end_ff   <= end_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_unit  = unit_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_string_end = end_ff;
   assign rsp_unit_count = count_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && end_ff |-> unit_ff == 16'd0 && last_ff)
      else $error("terminator must be zero and close its item");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !end_ff |-> count_ff != 12'd0)
      else $error("code unit with zero count");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> idx_in == 3'd0)
      else $error("burst index not rewound on pop");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the utf-8 to utf-16 transcoder core
module tb_top;
   import utt_pkg::*;

   localparam int ITEM_TARGET    = 500;
   localparam int QUIET_AFTER    = 430;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRINT_LIMIT    = 40;
   localparam int MAX_BURST      = 5;
   localparam logic [20:0] REPL_CODE = {5'd0, REPL_UNIT};

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        string_end;
      logic [11:0] unit_count;
   } unit_rec_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } byte_item_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        fin;
      logic        typed;
      logic [15:0] want_unit;
      logic [11:0] want_count;
   } dir_row_type;

   // short directed string at the reset capacity
   localparam dir_row_type DIRECTED [27] = '{
      '{8'h00, 1'b0, 1'b1, 16'h0000, 12'd1},
      '{8'h7F, 1'b0, 1'b1, 16'h007F, 12'd2},
      '{8'hFF, 1'b0, 1'b1, 16'hFFFD, 12'd3},
      '{8'h80, 1'b0, 1'b1, 16'hFFFD, 12'd4},
      '{8'hC2, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hA9, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hE2, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h82, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hAC, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hF0, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h9F, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h98, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h80, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hC0, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h80, 1'b0, 1'b1, 16'hFFFD, 12'd9},
      '{8'hED, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hA0, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h80, 1'b0, 1'b1, 16'hFFFD, 12'd10},
      '{8'hF7, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hBF, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hBF, 1'b0, 1'b1, 16'hFFFD, 12'd11},
      '{8'hE2, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h82, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h41, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'hF0, 1'b0, 1'b0, 16'h0000, 12'd0},
      '{8'h9F, 1'b1, 1'b0, 16'h0000, 12'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [15:0] rsp_code_unit;
   logic        rsp_run_last;
   logic        rsp_string_end;
   logic [11:0] rsp_unit_count;
   logic        csr_write_enable = 1'b0;
   logic [11:0] csr_write_data = 12'd0;

   utf8_to_utf16_transcoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_unit    (rsp_code_unit),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_end   (rsp_string_end),
      .rsp_unit_count   (rsp_unit_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // decoder shadow state
   logic [11:0]  cap_units = CAPACITY_RESET;
   logic [20:0]  acc_bits = '0;
   int           need_cnt = 0;
   int           seen_cnt = 0;
   int           written_cnt = 0;
   bit           out_full = 1'b0;
   unit_rec_type burst [$];

   unit_rec_type  expected_units [$];
   byte_item_type stim [$];

   int mismatch_cnt = 0;
   int checked_cnt = 0;
   int sent_cnt = 0;
   int strings_cnt = 0;
   int cap_writes = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   function automatic void push_unit(logic [15:0] u, logic term);
      unit_rec_type r;
      if (burst.size() >= MAX_BURST) return;
      r.code_unit  = u;
      r.run_last   = 1'b0;
      r.string_end = term;
      r.unit_count = written_cnt[11:0];
      burst.push_back(r);
   endfunction

   function automatic void emit_code(logic [20:0] cp);
      logic [20:0] v;
      if (out_full) return;
      if (cp >= SUPP_BASE) begin
         if (written_cnt + 2 > int'(cap_units)) begin
            out_full = 1'b1;
            return;
         end
         v = cp - SUPP_BASE;
         written_cnt++;
         push_unit(HIGH_SURR_BASE + {6'd0, v[19:10]}, 1'b0);
         written_cnt++;
         push_unit(LOW_SURR_BASE + {6'd0, v[9:0]}, 1'b0);
      end else begin
         if (written_cnt + 1 > int'(cap_units)) begin
            out_full = 1'b1;
            return;
         end
         written_cnt++;
         push_unit(cp[15:0], 1'b0);
      end
   endfunction

   function automatic void clear_seq();
      acc_bits = '0;
      need_cnt = 0;
      seen_cnt = 0;
   endfunction

   function automatic void flush_seq();
      if (need_cnt == 0) return;
      for (int k = 0; k <= seen_cnt; k++) emit_code(REPL_CODE);
      clear_seq();
   endfunction

   function automatic void open_seq(logic [7:0] b);
      if (b < 8'h80) begin
         emit_code({13'd0, b});
         return;
      end
      if (b[7:5] == 3'b110) begin
         need_cnt = 1;
         acc_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         need_cnt = 2;
         acc_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         need_cnt = 3;
         acc_bits = {18'd0, b[2:0]};
      end else begin
         emit_code(REPL_CODE);
         return;
      end
      seen_cnt = 0;
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      logic [20:0] cp;
      bit bad;
      if (need_cnt == 0) begin
         open_seq(b);
         return;
      end
      if (b[7:6] != 2'b10) begin
         flush_seq();
         open_seq(b);
         return;
      end
      acc_bits = {acc_bits[14:0], b[5:0]};
      seen_cnt++;
      if (seen_cnt < need_cnt) return;
      cp = acc_bits;
      if (need_cnt == 1) bad = cp < TWO_BYTE_MIN;
      else if (need_cnt == 2) bad = cp < THREE_BYTE_MIN || (cp >= 21'h00D800 && cp <= 21'h00DFFF);
      else bad = cp < SUPP_BASE || cp > CODE_MAX;
      clear_seq();
      emit_code(bad ? REPL_CODE : cp);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic fin);
      burst.delete();
      if (!out_full) absorb_byte(b);
      if (fin) begin
         flush_seq();
         push_unit(16'h0000, 1'b1);
         written_cnt = 0;
         out_full = 1'b0;
         clear_seq();
      end
      if (out_full) clear_seq();
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_cnt < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      mismatch_cnt++;
   endtask

   task automatic push_encoded(logic [20:0] cp, int nb, int keep);
      logic [7:0] b [4];
      b = '{8'h00, 8'h00, 8'h00, 8'h00};
      case (nb)
         1: b[0] = {1'b0, cp[6:0]};
         2: begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
         end
         3: begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
         end
         default: begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) stim.push_back('{b[i], 1'b0});
   endtask

   // mostly well-formed sequences, with noise, breaks and bad forms mixed in
   task automatic add_string();
      int n_seq;
      int kind;
      int nb;
      logic [20:0] cp;
      n_seq = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      for (int s = 0; s < n_seq; s++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            push_encoded(21'($urandom_range(0, 16'h7F)), 1, 1);
         end else if (kind < 48) begin
            push_encoded(21'($urandom_range(16'h80, 16'h7FF)), 2, 2);
         end else if (kind < 66) begin
            cp = 21'($urandom_range(16'h800, 16'hFFFF));
            if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h002000;
            push_encoded(cp, 3, 3);
         end else if (kind < 82) begin
            push_encoded(21'($urandom_range(32'h10000, 32'h10FFFF)), 4, 4);
         end else if (kind < 88) begin
            stim.push_back('{8'($urandom_range(0, 255)), 1'b0});
         end else if (kind < 93) begin
            nb = $urandom_range(2, 4);
            push_encoded(21'($urandom_range(0, 32'h1FFFFF)), nb, $urandom_range(1, nb - 1));
         end else if (kind < 97) begin
            case ($urandom_range(0, 4))
               0: push_encoded(21'($urandom_range(0, 16'h7F)), 2, 2);
               1: push_encoded(21'($urandom_range(0, 16'h7FF)), 3, 3);
               2: push_encoded(21'($urandom_range(0, 16'hFFFF)), 4, 4);
               3: push_encoded(21'($urandom_range(16'hD800, 16'hDFFF)), 3, 3);
               default: push_encoded(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4, 4);
            endcase
         end else begin
            nb = $urandom_range(2, 4);
            push_encoded(21'($urandom_range(0, 32'h1FFFFF)), nb, nb);
         end
      end
      stim[stim.size()-1].fin = 1'b1;
   endtask

   task automatic send_byte(logic [7:0] b, logic fin, bit typed, logic [15:0] t_unit,
                            logic [11:0] t_count);
      unit_rec_type r;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, fin);
      if (typed) begin
         r = '{t_unit, 1'b1, 1'b0, t_count};
         expected_units.push_back(r);
      end else begin
         foreach (burst[i]) expected_units.push_back(burst[i]);
      end
      sent_cnt++;
      if (fin) strings_cnt++;
   endtask

   task automatic set_capacity(logic [11:0] val);
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_units = val;
      cap_writes++;
   endtask

   task automatic wait_drained();
      while (expected_units.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (quiet) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      unit_rec_type want;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            report_mismatch("unexpected item, code_unit", rsp_code_unit, 0);
         end else begin
            want = expected_units.pop_front();
            checked_cnt++;
            if (rsp_code_unit !== want.code_unit)
               report_mismatch("code_unit", rsp_code_unit, want.code_unit);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_string_end !== want.string_end)
               report_mismatch("string_end", rsp_string_end, want.string_end);
            if (rsp_unit_count !== want.unit_count)
               report_mismatch("unit_count", rsp_unit_count, want.unit_count);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int phase;
      int burst_len;
      logic [11:0] new_cap;
      byte_item_type item;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].typed,
                   DIRECTED[i].want_unit, DIRECTED[i].want_count);
      req_valid <= 1'b0;

      while (sent_cnt < ITEM_TARGET || stim.size() > 0) begin
         wait_drained();
         case (phase % 8)
            0: new_cap = 12'd4095;
            1: new_cap = 12'd0;
            2: new_cap = 12'd1;
            3: new_cap = 12'd2;
            4: new_cap = 12'd3;
            5: new_cap = 12'($urandom_range(0, 40));
            6: new_cap = 12'($urandom_range(0, 4095));
            default: new_cap = CAPACITY_RESET;
         endcase
         set_capacity(new_cap);
         quiet = (sent_cnt >= QUIET_AFTER) || (phase % 3 == 2);
         burst_len = $urandom_range(30, 80);
         for (int i = 0; i < burst_len && (sent_cnt < ITEM_TARGET || stim.size() > 0); i++) begin
            if (stim.size() == 0) add_string();
            if (sent_cnt >= QUIET_AFTER) quiet = 1'b1;
            item = stim.pop_front();
            send_byte(item.data, item.fin, 1'b0, 16'h0000, 12'd0);
         end
         req_valid <= 1'b0;
         phase++;
      end

      wait_drained();
      $display("sent %0d bytes in %0d strings over %0d capacity settings", sent_cnt,
               strings_cnt, cap_writes);
      $display("checked %0d code units, %0d mismatches", checked_cnt, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== utf8_to_utf16_transcoder_core.f =====
hdl/utt_pkg.sv
hdl/utt_front.sv
hdl/utt_queue.sv
hdl/utt_back.sv
hdl/utf8_to_utf16_transcoder_core.sv
tb/sv/tb_top.sv
